// File: src/dfp_pkg.sv
// Shared constants, command codes and stage structs for the decimal fixed-point ALU.
package dfp_pkg;

  localparam int WHOLE_BITS_DEF = 32;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_CMP = 2'd3;

  localparam logic [13:0] FRAC_SCALE = 14'd10000;
  localparam logic [13:0] FRAC_MAX   = 14'd9999;

  // floor(x / 10000) equals (x * RECIP_10K) >> RECIP_SHIFT for every x below 2^32.
  localparam logic [31:0] RECIP_10K   = 32'd3518437209;
  localparam int          RECIP_SHIFT = 45;

  // Clamped operands handed to the multiplier pipeline.
  typedef struct packed {
    logic [31:0] aw;
    logic [13:0] af;
    logic [31:0] bw;
    logic [13:0] bf;
  } mul_op_t;

  // Everything outside the multiplier that rides along the pipeline.
  typedef struct packed {
    logic [1:0]  cmd;
    logic        less;
    logic        mul_neg;
    logic        add_neg;
    logic [32:0] add_whole;
    logic [13:0] add_frac;
  } side_t;

endpackage

// File: src/dfp_addsub.sv
// Operand cleanup, signed add/subtract and signed compare (combinational).
module dfp_addsub (
  input  logic [1:0]       cmd,
  input  logic             a_negative,
  input  logic [31:0]      a_whole,
  input  logic [13:0]      a_frac,
  input  logic             b_negative,
  input  logic [31:0]      b_whole,
  input  logic [13:0]      b_frac,
  output dfp_pkg::side_t   side,
  output dfp_pkg::mul_op_t mop
);
  import dfp_pkg::*;

  logic [13:0] af, bf;
  logic        a_zero, b_zero, an, bn, bn_eff;
  logic        a_ge_b, a_eq_b;
  logic [14:0] fsum;
  logic        carry;
  logic [13:0] big_f, small_f;
  logic [31:0] big_w, small_w;
  logic        borrow;
  logic [13:0] fdiff;

  always_comb begin
    af = (a_frac > FRAC_MAX) ? FRAC_MAX : a_frac;
    bf = (b_frac > FRAC_MAX) ? FRAC_MAX : b_frac;
    a_zero = (a_whole == 32'd0) && (af == 14'd0);
    b_zero = (b_whole == 32'd0) && (bf == 14'd0);
    // A magnitude of zero is always treated as positive.
    an = a_negative && !a_zero;
    bn = b_negative && !b_zero;
    bn_eff = (cmd == CMD_SUB) ? (!bn && !b_zero) : bn;

    a_eq_b = (a_whole == b_whole) && (af == bf);
    a_ge_b = (a_whole > b_whole) || ((a_whole == b_whole) && (af >= bf));

    fsum  = {1'b0, af} + {1'b0, bf};
    carry = fsum >= {1'b0, FRAC_SCALE};

    big_w   = a_ge_b ? a_whole : b_whole;
    small_w = a_ge_b ? b_whole : a_whole;
    big_f   = a_ge_b ? af : bf;
    small_f = a_ge_b ? bf : af;
    borrow  = big_f < small_f;
    fdiff   = borrow ? 14'(big_f + FRAC_SCALE - small_f) : 14'(big_f - small_f);

    side.cmd     = cmd;
    side.mul_neg = an ^ bn;
    if (an == bn_eff) begin
      side.add_neg   = an;
      side.add_frac  = carry ? 14'(fsum - {1'b0, FRAC_SCALE}) : fsum[13:0];
      side.add_whole = {1'b0, a_whole} + {1'b0, b_whole} + {32'd0, carry};
    end else begin
      side.add_neg   = a_ge_b ? an : bn_eff;
      side.add_frac  = fdiff;
      side.add_whole = {1'b0, big_w} - {1'b0, small_w} - {32'd0, borrow};
    end

    if (an != bn) begin
      side.less = an;
    end else if (!an) begin
      side.less = !a_ge_b;
    end else begin
      side.less = a_ge_b && !a_eq_b;
    end

    mop.aw = a_whole;
    mop.af = af;
    mop.bw = b_whole;
    mop.bf = bf;
  end

endmodule

// File: src/dfp_mul_pipe.sv
// Five-stage decimal fixed-point multiplier: exact product truncated to four digits.
module dfp_mul_pipe (
  input  logic             clk,
  input  logic [4:0]       en,
  input  dfp_pkg::mul_op_t mop,
  output logic [64:0]      whole,
  output logic [13:0]      frac
);
  import dfp_pkg::*;

  // Stage 1: raw products.
  logic [31:0] s1_aw, s1_bw;
  logic [13:0] s1_af, s1_bf;
  logic [63:0] s1_awm, s1_bwm, s1_ac;
  logic [26:0] s1_pf;

  // Stage 2: whole parts split in base 10000, fraction product scaled.
  logic [18:0] s2_a1, s2_b1;
  logic [13:0] s2_a0, s2_b0, s2_af, s2_bf;
  logic [58:0] s2_pfm;
  logic [63:0] s2_ac;

  // Stage 3: cross products.
  logic [26:0] s3_pa0, s3_pb0;
  logic [32:0] s3_pa1, s3_pb1;
  logic [13:0] s3_q;
  logic [63:0] s3_ac;

  // Stage 4: low-digit sum and its scaled value.
  logic [27:0] s4_x;
  logic [59:0] s4_xm;
  logic [33:0] s4_wa;
  logic [63:0] s4_ac;

  logic [18:0] a1_c, b1_c;
  logic [13:0] a0_c, b0_c, q_c;
  logic [27:0] x_c;
  logic [14:0] qx_c;

  always_comb begin
    a1_c = s1_awm[63:RECIP_SHIFT];
    b1_c = s1_bwm[63:RECIP_SHIFT];
    a0_c = 14'(s1_aw - 32'(a1_c) * 32'(FRAC_SCALE));
    b0_c = 14'(s1_bw - 32'(b1_c) * 32'(FRAC_SCALE));
    q_c  = s2_pfm[58:RECIP_SHIFT];
    x_c  = {1'b0, s3_pa0} + {1'b0, s3_pb0} + {14'd0, s3_q};
    qx_c = s4_xm[59:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_aw  <= mop.aw;
      s1_bw  <= mop.bw;
      s1_af  <= mop.af;
      s1_bf  <= mop.bf;
      s1_awm <= 64'(mop.aw) * 64'(RECIP_10K);
      s1_bwm <= 64'(mop.bw) * 64'(RECIP_10K);
      s1_ac  <= 64'(mop.aw) * 64'(mop.bw);
      s1_pf  <= 27'(28'(mop.af) * 28'(mop.bf));
    end
    if (en[1]) begin
      s2_a1  <= a1_c;
      s2_b1  <= b1_c;
      s2_a0  <= a0_c;
      s2_b0  <= b0_c;
      s2_af  <= s1_af;
      s2_bf  <= s1_bf;
      s2_pfm <= 59'(s1_pf) * 59'(RECIP_10K);
      s2_ac  <= s1_ac;
    end
    if (en[2]) begin
      s3_pa0 <= 27'(28'(s2_a0) * 28'(s2_bf));
      s3_pb0 <= 27'(28'(s2_b0) * 28'(s2_af));
      s3_pa1 <= 33'(s2_a1) * 33'(s2_bf);
      s3_pb1 <= 33'(s2_b1) * 33'(s2_af);
      s3_q   <= q_c;
      s3_ac  <= s2_ac;
    end
    if (en[3]) begin
      s4_x  <= x_c;
      s4_xm <= 60'(x_c) * 60'(RECIP_10K);
      s4_wa <= {1'b0, s3_pa1} + {1'b0, s3_pb1};
      s4_ac <= s3_ac;
    end
    if (en[4]) begin
      whole <= {1'b0, s4_ac} + {31'd0, s4_wa} + {50'd0, qx_c};
      frac  <= 14'(s4_x - 28'(qx_c) * 28'(FRAC_SCALE));
    end
  end

endmodule

// File: src/decimal_fixed_point_alu_core.sv
// Top level of the decimal fixed-point ALU: pipeline control, saturation and result register.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  cmd, a_*, b_*
//   out      from block out_valid / out_stall res_*, is_less, overflow
//
// One word is accepted every cycle while in_stall is low. An accepted word enters
// the first of the five multiplier stages on the accepting edge, moves through the
// other four, and then into the output register, where its result becomes valid.
// All command paths share the same latency, so results leave in order.
// Reset clears the valid bits only. A stall on the output freezes the filled
// stages; empty stages still take words, so bubbles are squeezed out.
module decimal_fixed_point_alu_core #(
  parameter int WHOLE_BITS = dfp_pkg::WHOLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic        a_negative,
  input  logic [31:0] a_whole,
  input  logic [13:0] a_frac,
  input  logic        b_negative,
  input  logic [31:0] b_whole,
  input  logic [13:0] b_frac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        res_negative,
  output logic [31:0] res_whole,
  output logic [13:0] res_frac,
  output logic        is_less,
  output logic        overflow
);
  import dfp_pkg::*;

  localparam logic [31:0] WMAX = (WHOLE_BITS >= 32) ? 32'hFFFF_FFFF
                                 : 32'((64'd1 << WHOLE_BITS) - 64'd1);

  side_t       side_c;
  mul_op_t     mop_c;
  side_t       side [1:5];
  logic [5:1]  vld;
  logic [6:1]  adv;
  logic [64:0] mul_whole;
  logic [13:0] mul_frac;

  logic [64:0] sel_whole;
  logic [13:0] sel_frac;
  logic        sel_neg, sat;
  logic        neg_next, less_next, ovf_next;
  logic [31:0] whole_next;
  logic [13:0] frac_next;

  dfp_addsub u_addsub (
    .cmd        (cmd),
    .a_negative (a_negative),
    .a_whole    (a_whole),
    .a_frac     (a_frac),
    .b_negative (b_negative),
    .b_whole    (b_whole),
    .b_frac     (b_frac),
    .side       (side_c),
    .mop        (mop_c)
  );

  dfp_mul_pipe u_mul (
    .clk   (clk),
    .en    (adv[5:1]),
    .mop   (mop_c),
    .whole (mul_whole),
    .frac  (mul_frac)
  );

  // A stage loads when it is empty or the stage after it is moving.
  always_comb begin
    adv[6] = !out_valid || !out_stall;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    in_stall = !adv[1];
  end

  always_comb begin
    if (side[5].cmd == CMD_MUL) begin
      sel_whole = mul_whole;
      sel_frac  = mul_frac;
      sel_neg   = side[5].mul_neg;
    end else begin
      sel_whole = {32'd0, side[5].add_whole};
      sel_frac  = side[5].add_frac;
      sel_neg   = side[5].add_neg;
    end
    sat = sel_whole > {33'd0, WMAX};

    if (side[5].cmd == CMD_CMP) begin
      neg_next   = 1'b0;
      whole_next = 32'd0;
      frac_next  = 14'd0;
      less_next  = side[5].less;
      ovf_next   = 1'b0;
    end else if (sat) begin
      neg_next   = sel_neg;
      whole_next = WMAX;
      frac_next  = FRAC_MAX;
      less_next  = 1'b0;
      ovf_next   = 1'b1;
    end else begin
      // A zero result is always reported as positive.
      neg_next   = sel_neg && ((sel_whole != 65'd0) || (sel_frac != 14'd0));
      whole_next = sel_whole[31:0];
      frac_next  = sel_frac;
      less_next  = 1'b0;
      ovf_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 5; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (adv[6]) begin
        out_valid <= vld[5];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side[1] <= side_c;
    end
    for (int k = 2; k <= 5; k++) begin
      if (adv[k]) begin
        side[k] <= side[k-1];
      end
    end
    if (adv[6]) begin
      res_negative <= neg_next;
      res_whole    <= whole_next;
      res_frac     <= frac_next;
      is_less      <= less_next;
      overflow     <= ovf_next;
    end
  end

endmodule
